>>> rtl/rprb_pkg.sv
// Shared types and constants for the RS-485 packet receive buffer.
package rprb_pkg;

   localparam int CHECKSUM_OFFSET = 2;
   localparam int LENGTH_OFFSET   = 4;

   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_MASTER_MODE = 1'b1;

   typedef enum logic [1:0] {
      OP_FRAME = 2'd0,
      OP_DONE  = 2'd1,
      OP_SKIP  = 2'd2,
      OP_READ  = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      PKT_IDLE      = 2'd0,
      PKT_MESSAGE   = 2'd1,
      PKT_WRONG_SUM = 2'd2
   } pkt_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_SCAN,
      BK_EVAL,
      BK_DISCARD,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_data;
      logic       address_bit;
      logic       overrun_error;
      logic       parity_error;
      logic       framing_error;
      logic [4:0] read_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  bus_state;
      logic [4:0]  waiting_count;
      logic [15:0] frame_length;
      logic [7:0]  read_byte;
      logic        receive_error;
      logic        overflow;
      logic        listening;
   } rsp_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  rx_data;
      logic        addr_frame;
      logic        addr_match;
      logic        line_err;
      logic [4:0]  read_offset;
   } op_type;

   typedef struct packed {
      logic [7:0] own_address;
      logic       master_mode;
   } cfg_type;

endpackage

>>> rtl/rprb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rprb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rprb_fifo.sv
// Small register FIFO used between the front, back and result sides.
module rprb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/rprb_front.sv
// Front end: accepts request items, decodes them into operations and queues them.
module rprb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rprb_pkg::req_type req_data,
   output logic              full,
   input  rprb_pkg::cfg_type cfg,
   input  logic              op_pop,
   output rprb_pkg::op_type  op_data,
   output logic              op_empty
);
   import rprb_pkg::*;

   op_type op_dec;

   // address compare here; user changes config only while idle; not enforced
   always_comb begin
      op_dec.kind        = op_kind_type'(req_data.kind);
      op_dec.rx_data     = req_data.rx_data;
      op_dec.addr_frame  = req_data.address_bit;
      op_dec.addr_match  = req_data.address_bit && (req_data.rx_data == cfg.own_address);
      op_dec.line_err    = req_data.overrun_error | req_data.parity_error
                           | req_data.framing_error;
      op_dec.read_offset = req_data.read_offset;
   end

   rprb_fifo #(
      .WIDTH($bits(op_type)),
      .DEPTH(2)
   ) u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(op_dec),
      .full     (full),
      .pop      (op_pop),
      .pop_data (op_data),
      .empty    (op_empty)
   );

endmodule

>>> rtl/rprb_back.sv
// Back end: ring buffer, header scan sequencer and packet status.
module rprb_back #(
   parameter int BUFFER_DEPTH = 32,
   parameter int HEADER_BYTES = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_empty,
   input  rprb_pkg::op_type  op_data,
   output logic              op_pop,
   input  rprb_pkg::cfg_type cfg,
   input  logic              res_full,
   output logic              res_push,
   output rprb_pkg::rsp_type res_data
);
   import rprb_pkg::*;

   localparam int PW   = $clog2(BUFFER_DEPTH);
   localparam int WW   = ((PW > 5) ? PW : 5) + 1;
   localparam int CNTW = $clog2(HEADER_BYTES + 1);
   localparam int LW   = 17;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                             input logic [WW-1:0] n);
      logic [WW-1:0] s;
      s = WW'(p) + n;
      if (s >= WW'(BUFFER_DEPTH)) begin
         s = s - WW'(BUFFER_DEPTH);
      end
      return s[PW-1:0];
   endfunction

   back_state_type state_ff, state_in;
   pkt_state_type  pkt_ff, pkt_in, pkt_chk;
   logic [PW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic           err_ff, err_in, ovf_ff, ovf_in, filter_ff, filter_in;
   logic [CNTW-1:0] cnt_ff, cnt_in, idx;
   logic [7:0]     sum_ff, sum_in, stored_ff, stored_in;
   logic [7:0]     hi_ff, hi_in, lo_ff, lo_in, rbyte_ff, rbyte_in;
   logic           scan_ok_ff, scan_ok_in, check_ff, check_in;
   logic           rearm_ff, rearm_in, pre_ff, pre_in;

   logic           ram_we;
   logic [PW-1:0]  ram_raddr;
   logic [7:0]     ram_rdata;

   logic [WW-1:0]  wait_sum, wait_ext;
   logic [PW-1:0]  wait_cnt, wp_next;
   logic           buf_full, hdr_ok, listening;
   logic [LW-1:0]  len_full, disc;

   // one slot is kept free so that full and empty differ
   assign wait_sum  = WW'(wp_ff) - WW'(rp_ff) + ((wp_ff < rp_ff) ? WW'(BUFFER_DEPTH) : '0);
   assign wait_cnt  = wait_sum[PW-1:0];
   assign wait_ext  = WW'(wait_cnt);
   assign wp_next   = advance(wp_ff, WW'(1));
   assign buf_full  = (wp_next == rp_ff);
   assign hdr_ok    = (wait_ext >= WW'(HEADER_BYTES));
   assign listening = filter_ff && !cfg.master_mode;
   assign len_full  = LW'(HEADER_BYTES) + LW'({hi_ff, lo_ff});
   assign idx       = cnt_ff - 1'b1;

   always_comb begin
      pkt_chk = pkt_ff;
      if (check_ff && scan_ok_ff) begin
         if (sum_ff != stored_ff) begin
            pkt_chk = PKT_WRONG_SUM;
         end else if (LW'(wait_cnt) == len_full) begin
            pkt_chk = PKT_MESSAGE;
         end
      end
   end

   always_comb begin
      disc = scan_ok_ff ? len_full : LW'(wait_cnt);
      if (disc > LW'(wait_cnt)) begin
         disc = LW'(wait_cnt);
      end
   end

   always_comb begin
      state_in   = state_ff;
      pkt_in     = pkt_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      err_in     = err_ff;
      ovf_in     = ovf_ff;
      filter_in  = filter_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      stored_in  = stored_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      rbyte_in   = rbyte_ff;
      scan_ok_in = scan_ok_ff;
      check_in   = check_ff;
      rearm_in   = rearm_ff;
      pre_in     = pre_ff;
      ram_we     = 1'b0;
      ram_raddr  = advance(rp_ff, WW'(cnt_ff));
      op_pop     = 1'b0;
      res_push   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!op_empty) begin
               op_pop   = 1'b1;
               rbyte_in = '0;
               check_in = 1'b0;
               rearm_in = 1'b0;
               pre_in   = 1'b0;
               cnt_in   = '0;
               state_in = BK_SCAN;
               case (op_data.kind)
                  OP_FRAME: begin
                     // data frames are ignored outright while the filter is armed and master mode is off
                     if (!(listening && !op_data.addr_frame)) begin
                        if (op_data.addr_match) begin
                           filter_in = 1'b0;
                        end
                        if (op_data.line_err) begin
                           err_in = 1'b1;
                        end else if (buf_full) begin
                           ovf_in = 1'b1;
                        end else begin
                           ram_we   = 1'b1;
                           wp_in    = wp_next;
                           check_in = 1'b1;
                           rearm_in = 1'b1;
                        end
                     end
                  end
                  OP_DONE: begin
                     pre_in = 1'b1;
                  end
                  OP_SKIP: begin
                     if (wait_cnt != '0) begin
                        rp_in = advance(rp_ff, WW'(1));
                     end
                     pkt_in   = PKT_IDLE;
                     check_in = 1'b1;
                  end
                  OP_READ: begin
                     if (WW'(op_data.read_offset) < wait_ext) begin
                        ram_raddr = advance(rp_ff, WW'(op_data.read_offset));
                        state_in  = BK_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_READ: begin
            rbyte_in = ram_rdata;
            state_in = BK_SCAN;
         end
         BK_SCAN: begin
            // read address leads the consumed byte by one position, as the RAM read data is registered
            if (!hdr_ok) begin
               scan_ok_in = 1'b0;
               state_in   = BK_EVAL;
            end else begin
               if (cnt_ff == '0) begin
                  sum_in = '0;
               end else if (idx == CNTW'(CHECKSUM_OFFSET)) begin
                  stored_in = ram_rdata;
               end else begin
                  sum_in = sum_ff + ram_rdata;
               end
               if (cnt_ff != '0 && idx == CNTW'(LENGTH_OFFSET)) begin
                  hi_in = ram_rdata;
               end
               if (cnt_ff != '0 && idx == CNTW'(LENGTH_OFFSET + 1)) begin
                  lo_in = ram_rdata;
               end
               if (cnt_ff == CNTW'(HEADER_BYTES)) begin
                  scan_ok_in = 1'b1;
                  cnt_in     = '0;
                  state_in   = BK_EVAL;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         BK_EVAL: begin
            if (pre_ff) begin
               state_in = BK_DISCARD;
            end else begin
               pkt_in = pkt_chk;
               if (rearm_ff && pkt_chk == PKT_MESSAGE) begin
                  filter_in = 1'b1;
               end
               state_in = BK_RESULT;
            end
         end
         BK_DISCARD: begin
            rp_in    = advance(rp_ff, WW'(disc[PW-1:0]));
            pkt_in   = PKT_IDLE;
            pre_in   = 1'b0;
            check_in = 1'b1;
            cnt_in   = '0;
            state_in = BK_SCAN;
         end
         BK_RESULT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         pkt_ff     <= PKT_IDLE;
         wp_ff      <= '0;
         rp_ff      <= '0;
         err_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
         filter_ff  <= 1'b1;
         cnt_ff     <= '0;
         scan_ok_ff <= 1'b0;
         check_ff   <= 1'b0;
         rearm_ff   <= 1'b0;
         pre_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pkt_ff     <= pkt_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         err_ff     <= err_in;
         ovf_ff     <= ovf_in;
         filter_ff  <= filter_in;
         cnt_ff     <= cnt_in;
         scan_ok_ff <= scan_ok_in;
         check_ff   <= check_in;
         rearm_ff   <= rearm_in;
         pre_ff     <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      stored_ff <= stored_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      rbyte_ff  <= rbyte_in;
   end

   rprb_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wp_ff),
      .wr_data(op_data.rx_data),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      res_data.bus_state     = pkt_ff;
      res_data.waiting_count = wait_ext[4:0];
      if (!scan_ok_ff) begin
         res_data.frame_length = '0;
      end else if (len_full[LW-1]) begin
         res_data.frame_length = '1;
      end else begin
         res_data.frame_length = len_full[15:0];
      end
      res_data.read_byte     = rbyte_ff;
      res_data.receive_error = err_ff;
      res_data.overflow      = ovf_ff;
      res_data.listening     = listening;
   end

endmodule

>>> rtl/rs485_packet_receive_buffer_core.sv
// Top level: RS-485 packet receive buffer with request/result queues and CSRs.
// A received frame or skip passes the header scan, evaluation and the result state, and a
// read of a waiting byte first passes the read state; the scan ends early while fewer than
// HEADER_BYTES bytes wait. Packet done scans the header twice, around the discard.
// The back end takes one item at a time; the header scan, which reads one buffered
// byte per cycle through the ring RAM's single read port, paces it.
// Reset clears pointers, status, sticky flags and both queues and arms the address filter;
// buffer contents are not cleared.
module rs485_packet_receive_buffer_core #(
   parameter int BUFFER_DEPTH = 32,
   parameter int HEADER_BYTES = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rprb_pkg::req_type req_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output rprb_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);
   import rprb_pkg::*;

   logic [7:0] own_address_ff, own_address_in;
   logic       master_mode_ff, master_mode_in;
   cfg_type    cfg;
   op_type     op_data;
   logic       op_empty, op_pop;
   rsp_type    res_data;
   logic       res_push, res_full;

   always_comb begin
      own_address_in = own_address_ff;
      master_mode_in = master_mode_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_OWN_ADDRESS: own_address_in = csr_data;
            CSR_MASTER_MODE: master_mode_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         master_mode_ff <= 1'b0;
      end else begin
         own_address_ff <= own_address_in;
         master_mode_ff <= master_mode_in;
      end
   end

   assign cfg.own_address = own_address_ff;
   assign cfg.master_mode = master_mode_ff;

   rprb_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .req_data(req_data),
      .full    (full),
      .cfg     (cfg),
      .op_pop  (op_pop),
      .op_data (op_data),
      .op_empty(op_empty)
   );

   rprb_back #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .op_empty(op_empty),
      .op_data (op_data),
      .op_pop  (op_pop),
      .cfg     (cfg),
      .res_full(res_full),
      .res_push(res_push),
      .res_data(res_data)
   );

   rprb_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_data),
      .full     (res_full),
      .pop      (pop),
      .pop_data (rsp_data),
      .empty    (empty)
   );

   // the back end only transfers a result when the queue has room
   assert property (@(posedge clock) disable iff (reset) !(res_push && res_full))
      else $error("result transfer into a full queue");

   // a nonzero length always covers at least the header
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.frame_length != 16'd0) |-> rsp_data.frame_length >= 16'(HEADER_BYTES))
      else $error("frame length below header size");

   // a raised status implies a complete header is buffered
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.bus_state != PKT_IDLE) |-> rsp_data.frame_length != 16'd0)
      else $error("packet status raised without a header");

endmodule

>>> tb/sv/rs485_packet_receive_buffer_core_tb.sv
// Self-checking testbench for the RS-485 packet receive buffer core.
module rs485_packet_receive_buffer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rprb_pkg::*;

   localparam int DEPTH         = 32;
   localparam int HDR           = 6;
   localparam int SETTLE_CYCLES = 40;

   logic       clock = 1'b0;
   logic       reset;
   logic       push;
   req_type    req_data;
   logic       full;
   logic       empty;
   logic       pop;
   rsp_type    rsp_data;
   logic       csr_write;
   logic       csr_index;
   logic [7:0] csr_data;

   rs485_packet_receive_buffer_core #(
      .BUFFER_DEPTH(DEPTH),
      .HEADER_BYTES(HDR)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #5 clock = ~clock;

   // Receive buffer mirror
   logic [7:0]    ring [DEPTH];
   int            wr_ptr       = 0;
   int            rd_ptr       = 0;
   pkt_state_type pkt          = PKT_IDLE;
   bit            err_flag     = 1'b0;
   bit            ovf_flag     = 1'b0;
   bit            filter_armed = 1'b1;
   logic [7:0]    own_addr     = 8'h00;
   bit            master_on    = 1'b0;

   req_type pending_items_q[$];
   rsp_type expected_status_q[$];
   rsp_type want;

   int items_loaded    = 0;
   int items_accepted  = 0;
   int accepted_seen   = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int messages_seen   = 0;
   int bad_sums_seen   = 0;
   int overflow_seen   = 0;
   int line_err_seen   = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;

   function automatic int held_bytes();
      return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
   endfunction

   // header plus payload length, 0 while the header is incomplete
   function automatic int pkt_length();
      if (held_bytes() < HDR) return 0;
      return HDR + int'({ring[(rd_ptr + LENGTH_OFFSET) % DEPTH],
                         ring[(rd_ptr + LENGTH_OFFSET + 1) % DEPTH]});
   endfunction

   function automatic void recheck_header();
      int         n;
      logic [7:0] sum;
      n = held_bytes();
      if (n < HDR) return;
      sum = 8'h00;
      for (int i = 0; i < HDR; i++)
         if (i != CHECKSUM_OFFSET) sum += ring[(rd_ptr + i) % DEPTH];
      if (sum != ring[(rd_ptr + CHECKSUM_OFFSET) % DEPTH]) pkt = PKT_WRONG_SUM;
      else if (n == pkt_length()) pkt = PKT_MESSAGE;
   endfunction

   function automatic void store_frame(req_type it);
      int nxt;
      if (filter_armed && !master_on && !it.address_bit) return;
      if (it.address_bit && it.rx_data == own_addr) filter_armed = 1'b0;
      if (it.overrun_error || it.parity_error || it.framing_error) begin
         err_flag = 1'b1;
         return;
      end
      nxt = (wr_ptr + 1) % DEPTH;
      if (nxt == rd_ptr) begin
         ovf_flag = 1'b1;
         return;
      end
      ring[wr_ptr] = it.rx_data;
      wr_ptr = nxt;
      recheck_header();
      if (pkt == PKT_MESSAGE) filter_armed = 1'b1;
   endfunction

   // Advance the mirror by one item and return the status it should produce
   function automatic rsp_type apply_item(req_type it);
      rsp_type    r;
      int         n;
      int         len;
      logic [7:0] rd_val;
      rd_val = 8'h00;
      case (it.kind)
         OP_FRAME: store_frame(it);
         OP_DONE: begin
            n = held_bytes();
            len = pkt_length();
            if (len == 0 || len > n) len = n;
            rd_ptr = (rd_ptr + len) % DEPTH;
            pkt = PKT_IDLE;
            recheck_header();
         end
         OP_SKIP: begin
            if (held_bytes() > 0) rd_ptr = (rd_ptr + 1) % DEPTH;
            pkt = PKT_IDLE;
            recheck_header();
         end
         OP_READ: begin
            if (it.read_offset < held_bytes())
               rd_val = ring[(rd_ptr + it.read_offset) % DEPTH];
         end
         default: begin
         end
      endcase
      len = pkt_length();
      if (len > 65535) len = 65535;
      r.bus_state     = pkt;
      r.waiting_count = 5'(held_bytes());
      r.frame_length  = 16'(len);
      r.read_byte     = rd_val;
      r.receive_error = err_flag;
      r.overflow      = ovf_flag;
      r.listening     = filter_armed && !master_on;
      return r;
   endfunction

   function automatic string show(rsp_type s);
      return $sformatf("state=%0d held=%0d len=%0d byte=%02h err=%0b ovf=%0b listen=%0b",
                       s.bus_state, s.waiting_count, s.frame_length, s.read_byte,
                       s.receive_error, s.overflow, s.listening);
   endfunction

   // Result side: check first so a same-edge accept never satisfies a stale result
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_status_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected status transfer at %0t: %s", $time, show(rsp_data));
            end else begin
               want = expected_status_q.pop_front();
               results_checked++;
               if (rsp_data.bus_state     !== want.bus_state     ||
                   rsp_data.waiting_count !== want.waiting_count ||
                   rsp_data.frame_length  !== want.frame_length  ||
                   rsp_data.read_byte     !== want.read_byte     ||
                   rsp_data.receive_error !== want.receive_error ||
                   rsp_data.overflow      !== want.overflow      ||
                   rsp_data.listening     !== want.listening) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("status mismatch at %0t", $time);
                     $display("  expected %s", show(want));
                     $display("  actual   %s", show(rsp_data));
                  end
               end
               if (want.bus_state == PKT_MESSAGE) messages_seen++;
               if (want.bus_state == PKT_WRONG_SUM) bad_sums_seen++;
               if (want.overflow) overflow_seen++;
               if (want.receive_error) line_err_seen++;
            end
         end
         if (push && !full) begin
            expected_status_q.push_back(apply_item(req_data));
            items_accepted++;
         end
      end
   end

   // Request side driver and result-side stall generator
   always @(negedge clock) begin
      if (!reset) begin
         if (!push || items_accepted != accepted_seen) begin
            if (pending_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               push     <= 1'b1;
               req_data <= pending_items_q.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
         accepted_seen = items_accepted;
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_item(req_type it);
      pending_items_q.push_back(it);
      items_loaded++;
   endtask

   function automatic logic [2:0] line_err(int pct);
      return ($urandom_range(99) < pct) ? 3'($urandom_range(1, 7)) : 3'b000;
   endfunction

   // Unused fields are randomized so every input bit toggles
   function automatic req_type frame_item(logic [7:0] d, bit is_addr, logic [2:0] errs);
      req_type     it;
      logic [31:0] raw;
      raw = $urandom;
      it = raw[$bits(req_type)-1:0];
      it.kind = OP_FRAME;
      it.rx_data = d;
      it.address_bit = is_addr;
      {it.overrun_error, it.parity_error, it.framing_error} = errs;
      return it;
   endfunction

   function automatic req_type op_item(op_kind_type k, logic [4:0] off);
      req_type     it;
      logic [31:0] raw;
      raw = $urandom;
      it = raw[$bits(req_type)-1:0];
      it.kind = k;
      it.read_offset = off;
      return it;
   endfunction

   // Header is b0 b1 sum b3 len_hi len_lo, then the payload
   task automatic load_packet(logic [7:0] b0, bit b0_addr, logic [15:0] len, int body,
                              bit bad_sum, int err_pct);
      logic [7:0] b1;
      logic [7:0] b3;
      logic [7:0] sum;
      b1 = 8'($urandom);
      b3 = 8'($urandom);
      sum = b0 + b1 + b3 + len[15:8] + len[7:0];
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      queue_item(frame_item(b0, b0_addr, line_err(err_pct)));
      queue_item(frame_item(b1, 1'b0, line_err(err_pct)));
      queue_item(frame_item(sum, 1'b0, line_err(err_pct)));
      queue_item(frame_item(b3, 1'b0, line_err(err_pct)));
      queue_item(frame_item(len[15:8], 1'b0, line_err(err_pct)));
      queue_item(frame_item(len[7:0], 1'b0, line_err(err_pct)));
      repeat (body) queue_item(frame_item(8'($urandom), 1'b0, line_err(err_pct)));
   endtask

   task automatic load_random_traffic(int target);
      int          counted;
      int          body;
      int          pick;
      logic [15:0] len;
      logic [31:0] raw;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            // stray data frames ahead of a packet, mostly dropped by the filter
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(1, 3))
                  queue_item(frame_item(8'($urandom), 1'b0, line_err(30)));
            len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            body = (len > 24) ? $urandom_range(0, 24) : int'(len);
            if (body > 0 && $urandom_range(7) == 0) body--;
            load_packet(($urandom_range(6) == 0) ? 8'($urandom) : own_addr,
                        $urandom_range(19) != 0, len, body, $urandom_range(9) == 0, 3);
            counted += HDR + body;
            repeat ($urandom_range(0, 3)) begin
               queue_item(op_item(OP_READ, 5'($urandom)));
               counted++;
            end
            if ($urandom_range(3) != 0) begin
               queue_item(op_item(OP_DONE, 5'($urandom)));
               counted++;
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  queue_item(op_item(OP_SKIP, 5'($urandom)));
                  counted++;
               end
            end
         end else if (pick < 80) begin
            queue_item(op_item(op_kind_type'($urandom_range(1, 3)), 5'($urandom)));
            counted++;
         end else begin
            raw = $urandom;
            queue_item(raw[$bits(req_type)-1:0]);
            counted++;
         end
      end
   endtask

   task automatic wait_drained();
      while (items_accepted != items_loaded || expected_status_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      if (idx == CSR_OWN_ADDRESS) own_addr = val;
      else master_on = val[0];
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int phase;
      reset     = 1'b1;
      push      = 1'b0;
      pop       = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = CSR_OWN_ADDRESS;
      csr_data  = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_reg(CSR_OWN_ADDRESS, 8'h5A);
               write_reg(CSR_MASTER_MODE, 8'h00);
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               write_reg(CSR_OWN_ADDRESS, 8'h00);
               write_reg(CSR_MASTER_MODE, 8'h01);
               send_idle_pct  = 81;
               recv_stall_pct = 0;
            end
            2: begin
               write_reg(CSR_OWN_ADDRESS, 8'hFF);
               write_reg(CSR_MASTER_MODE, 8'h00);
               send_idle_pct  = 0;
               recv_stall_pct = 81;
            end
            default: begin
               write_reg(CSR_OWN_ADDRESS, 8'($urandom));
               send_idle_pct  = 38;
               recv_stall_pct = 38;
            end
         endcase

         if (phase == 0) begin
            // empty buffer: reads give zero, skip and done leave the pointers alone
            queue_item(op_item(OP_READ, 5'd0));
            queue_item(op_item(OP_READ, 5'd31));
            queue_item(op_item(OP_SKIP, 5'd0));
            queue_item(op_item(OP_DONE, 5'd0));
            // data with every line error while listening: ignored outright
            queue_item(frame_item(8'hFF, 1'b0, 3'b111));
            // own address with a framing error opens the filter but is dropped
            queue_item(frame_item(own_addr, 1'b1, 3'b001));
            // complete message with one payload byte re-arms the filter
            load_packet(8'h00, 1'b0, 16'd1, 1, 1'b0, 0);
            queue_item(op_item(OP_READ, 5'd0));
            queue_item(op_item(OP_READ, 5'd6));
            queue_item(op_item(OP_READ, 5'd7));
            queue_item(op_item(OP_READ, 5'd31));
            queue_item(frame_item(8'h00, 1'b0, 3'b100));
            queue_item(op_item(OP_DONE, 5'd0));
            // maximum payload length: frame length saturates, done clears it all
            load_packet(own_addr, 1'b1, 16'hFFFF, 0, 1'b0, 0);
            queue_item(op_item(OP_DONE, 5'd0));
         end
         load_random_traffic(350);
      end
      wait_drained();

      $display("Checked %0d status transfers over four flow-control phases, %0d mismatches.",
               results_checked, mismatch_count);
      $display("Complete messages %0d, bad header sums %0d, overflow %0d, line errors %0d.",
               messages_seen, bad_sums_seen, overflow_seen, line_err_seen);
      if (mismatch_count == 0) begin
         $display("** rs485_packet_receive_buffer_core: PASSED **");
      end else begin
         $display("** rs485_packet_receive_buffer_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: %0d items accepted, %0d transfers still owed.",
               items_accepted, expected_status_q.size());
      $display("** rs485_packet_receive_buffer_core: FAILED **");
      $finish;
   end

endmodule
